// ===== hw/rtl/owvm_pkg.sv =====
// ----------------------------------------------------------------------------
// owvm_pkg: shared definitions for the omni wheel velocity mixer
// Widths, mixing coefficients, operation codes and the sine table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package owvm_pkg;

    // Operation codes of the command word.
    localparam logic OP_POLAR = 1'b0;
    localparam logic OP_CART  = 1'b1;

    // Parameter defaults.
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int CMD_WIDTH_DEF      = 12;
    localparam int MAX_TRIG_FRAC      = 20;

    // Fixed field widths.
    localparam int ANGLE_W = 10;
    localparam int LIMIT_W = 7;
    localparam int WHEEL_W = 24;
    localparam int COEF_W  = 15;
    localparam int Q16_SH  = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd40;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Mixing coefficients in Q16, polar set and cartesian set.
    localparam logic signed [COEF_W-1:0] POL_A = 15'sd3736;
    localparam logic signed [COEF_W-1:0] POL_C = 15'sd2163;
    localparam logic signed [COEF_W-1:0] POL_S = 15'sd4260;
    localparam logic signed [COEF_W-1:0] POL_R = 15'sd9241;
    localparam logic signed [COEF_W-1:0] CAR_A = 15'sd3670;
    localparam logic signed [COEF_W-1:0] CAR_C = 15'sd2163;
    localparam logic signed [COEF_W-1:0] CAR_S = 15'sd4260;
    localparam logic signed [COEF_W-1:0] CAR_R = 15'sd9175;

    // Sine of whole degrees 0..90, wide enough for the largest fraction width.
    localparam int SIN_W = MAX_TRIG_FRAC + 1;
    typedef logic [SIN_W-1:0] t_sin_tab [0:90];

    localparam logic [63:0] DEG_Q30 = 64'd18740330;
    localparam logic [63:0] TAYLOR_DIV [0:7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Builds the table at elaboration: a nine-term Taylor series in Q30 with
    // every step truncated, then rounded half up to frac bits and capped at 1.0.
    function automatic t_sin_tab sin_table(input int frac);
        t_sin_tab    tab;
        logic [63:0] xr;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] one;
        for (int k = 0; k <= 90; k++) begin
            xr   = 64'(k) * DEG_Q30;
            x2   = (xr * xr) >> 30;
            term = xr;
            sum  = xr;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sum = (sum + (64'd1 << (29 - frac))) >> (30 - frac);
            one = 64'd1 << frac;
            if (sum > one) begin
                sum = one;
            end
            tab[k] = sum[SIN_W-1:0];
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/owvm_front.sv =====
// ----------------------------------------------------------------------------
// owvm_front: command classification and polar to cartesian conversion
// Two stages: classify and fold the heading, then table lookup and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module owvm_front #(
    parameter int TRIG_FRAC_BITS = owvm_pkg::TRIG_FRAC_BITS_DEF,
    parameter int CMD_WIDTH      = owvm_pkg::CMD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic                                  i_op,
    input  logic signed [owvm_pkg::ANGLE_W-1:0]   i_angle_deg,
    input  logic signed [CMD_WIDTH-1:0]           i_magnitude,
    input  logic signed [CMD_WIDTH-1:0]           i_vel_x,
    input  logic signed [CMD_WIDTH-1:0]           i_vel_y,
    input  logic signed [CMD_WIDTH-1:0]           i_rotation,
    output logic                                  o_push,
    output logic                                  o_cart,
    output logic                                  o_stop,
    output logic signed [CMD_WIDTH:0]             o_fx,
    output logic signed [CMD_WIDTH:0]             o_fy,
    output logic signed [CMD_WIDTH:0]             o_fw,
    output logic [1:0]                            o_inflight
);
    import owvm_pkg::*;

    localparam int FW = CMD_WIDTH + 1;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = CMD_WIDTH + TRIG_FRAC_BITS + 2;

    localparam t_sin_tab SIN_TAB = sin_table(TRIG_FRAC_BITS);
    localparam logic signed [PW-1:0] TRUNC_BIAS = PW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;

    // Stage 1: classify and fold the heading into the first quadrant.
    logic                 n_f1_trig, n_f1_stop, n_f1_cneg, n_f1_sneg;
    logic [6:0]           n_f1_ci, n_f1_si;
    logic signed [FW-1:0] n_f1_fx, n_f1_fy, n_f1_fw;
    logic signed [FW-1:0] mag_ext;
    logic [8:0]           ang_u;
    logic [8:0]           ci_full, si_full;

    logic                   r_f1_valid, r_f1_trig, r_f1_cart, r_f1_stop, r_f1_cneg, r_f1_sneg;
    logic [6:0]             r_f1_ci, r_f1_si;
    logic signed [CMD_WIDTH-1:0] r_f1_mag;
    logic signed [FW-1:0]   r_f1_fx, r_f1_fy, r_f1_fw;

    assign mag_ext = {i_magnitude[CMD_WIDTH-1], i_magnitude};
    assign ang_u   = i_angle_deg[8:0];

    always_comb begin
        n_f1_trig = 1'b0;
        n_f1_stop = 1'b0;
        n_f1_cneg = 1'b0;
        n_f1_sneg = 1'b0;
        ci_full   = '0;
        si_full   = '0;
        n_f1_fx   = '0;
        n_f1_fy   = '0;
        n_f1_fw   = {i_rotation[CMD_WIDTH-1], i_rotation};
        if (i_op == OP_CART) begin
            n_f1_fx   = {i_vel_x[CMD_WIDTH-1], i_vel_x};
            n_f1_fy   = {i_vel_y[CMD_WIDTH-1], i_vel_y};
            n_f1_stop = (i_vel_x == '0) && (i_vel_y == '0) && (i_rotation == '0);
        end else if (i_angle_deg[ANGLE_W-1]) begin
            n_f1_fw = -mag_ext;
        end else if (ang_u >= DEG_360) begin
            n_f1_fw = mag_ext;
        end else begin
            n_f1_trig = 1'b1;
            if (ang_u <= DEG_90) begin
                ci_full = DEG_90 - ang_u;
                si_full = ang_u;
            end else if (ang_u <= DEG_180) begin
                ci_full   = ang_u - DEG_90;
                si_full   = DEG_180 - ang_u;
                n_f1_cneg = 1'b1;
            end else if (ang_u <= DEG_270) begin
                ci_full   = DEG_270 - ang_u;
                si_full   = ang_u - DEG_180;
                n_f1_cneg = 1'b1;
                n_f1_sneg = 1'b1;
            end else begin
                ci_full   = ang_u - DEG_270;
                si_full   = DEG_360 - ang_u;
                n_f1_sneg = 1'b1;
            end
        end
    end

    assign n_f1_ci = ci_full[6:0];
    assign n_f1_si = si_full[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= i_accept;
        end
        r_f1_trig <= n_f1_trig;
        r_f1_cart <= (i_op == OP_CART);
        r_f1_stop <= n_f1_stop;
        r_f1_cneg <= n_f1_cneg;
        r_f1_sneg <= n_f1_sneg;
        r_f1_ci   <= n_f1_ci;
        r_f1_si   <= n_f1_si;
        r_f1_mag  <= i_magnitude;
        r_f1_fx   <= n_f1_fx;
        r_f1_fy   <= n_f1_fy;
        r_f1_fw   <= n_f1_fw;
    end

    // Stage 2: signed cosine and sine times the magnitude.
    logic signed [TW-1:0] cos_s, sin_s;
    logic signed [PW-1:0] n_f2_px, n_f2_py;

    logic                 r_f2_valid, r_f2_trig, r_f2_cart, r_f2_stop;
    logic signed [PW-1:0] r_f2_px, r_f2_py;
    logic signed [FW-1:0] r_f2_fx, r_f2_fy, r_f2_fw;

    always_comb begin
        cos_s = signed'({1'b0, SIN_TAB[r_f1_ci][TRIG_FRAC_BITS:0]});
        sin_s = signed'({1'b0, SIN_TAB[r_f1_si][TRIG_FRAC_BITS:0]});
        if (r_f1_cneg) begin
            cos_s = -cos_s;
        end
        if (r_f1_sneg) begin
            sin_s = -sin_s;
        end
        n_f2_px = PW'(r_f1_mag) * PW'(cos_s);
        n_f2_py = PW'(r_f1_mag) * PW'(sin_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else begin
            r_f2_valid <= r_f1_valid;
        end
        r_f2_trig <= r_f1_trig;
        r_f2_cart <= r_f1_cart;
        r_f2_stop <= r_f1_stop;
        r_f2_px   <= n_f2_px;
        r_f2_py   <= n_f2_py;
        r_f2_fx   <= r_f1_fx;
        r_f2_fy   <= r_f1_fy;
        r_f2_fw   <= r_f1_fw;
    end

    // Drop the fraction bits, rounding toward zero.
    logic signed [PW-1:0] qx, qy;

    assign qx = (r_f2_px + (r_f2_px[PW-1] ? TRUNC_BIAS : '0)) >>> TRIG_FRAC_BITS;
    assign qy = (r_f2_py + (r_f2_py[PW-1] ? TRUNC_BIAS : '0)) >>> TRIG_FRAC_BITS;

    assign o_push     = r_f2_valid;
    assign o_cart     = r_f2_cart;
    assign o_stop     = r_f2_stop;
    assign o_fx       = r_f2_trig ? qx[FW-1:0] : r_f2_fx;
    assign o_fy       = r_f2_trig ? qy[FW-1:0] : r_f2_fy;
    assign o_fw       = r_f2_fw;
    assign o_inflight = {1'b0, r_f1_valid} + {1'b0, r_f2_valid};

endmodule

`default_nettype wire

// ===== hw/rtl/owvm_queue.sv =====
// ----------------------------------------------------------------------------
// owvm_queue: short first-in first-out queue between front and back
// Register array with a combinational read of the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module owvm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = owvm_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import owvm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(DEPTH)) || i_pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

`default_nettype wire

// ===== hw/rtl/owvm_back.sv =====
// ----------------------------------------------------------------------------
// owvm_back: wheel mixing and clamping
// Coefficient products, then wheel sums and the symmetric clamp into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module owvm_back #(
    parameter int CMD_WIDTH = owvm_pkg::CMD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [owvm_pkg::LIMIT_W-1:0]          i_limit,
    input  logic                                  i_q_empty,
    input  logic                                  i_cart,
    input  logic                                  i_stop,
    input  logic signed [CMD_WIDTH:0]             i_fx,
    input  logic signed [CMD_WIDTH:0]             i_fy,
    input  logic signed [CMD_WIDTH:0]             i_fw,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [owvm_pkg::WHEEL_W-1:0]   o_wheel_one,
    output logic signed [owvm_pkg::WHEEL_W-1:0]   o_wheel_two,
    output logic signed [owvm_pkg::WHEEL_W-1:0]   o_wheel_three,
    output logic                                  o_stop_request
);
    import owvm_pkg::*;

    localparam int PW = CMD_WIDTH + 1 + COEF_W;
    localparam int SW = PW + 2;

    logic en_out, en_b1;

    logic r_out_valid, r_b1_valid;

    assign en_out = !r_out_valid || !i_out_stall;
    assign en_b1  = !r_b1_valid || en_out;
    assign o_pop  = !i_q_empty && en_b1;

    // Stage 1: coefficient products.
    logic signed [COEF_W-1:0] coef_a, coef_c, coef_s, coef_r;
    logic signed [PW-1:0]     r_ax, r_cy, r_sy, r_rw;
    logic                     r_b1_stop;

    assign coef_a = i_cart ? CAR_A : POL_A;
    assign coef_c = i_cart ? CAR_C : POL_C;
    assign coef_s = i_cart ? CAR_S : POL_S;
    assign coef_r = i_cart ? CAR_R : POL_R;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (en_b1) begin
            r_b1_valid <= o_pop;
        end
        if (o_pop) begin
            r_ax      <= PW'(i_fx) * PW'(coef_a);
            r_cy      <= PW'(i_fy) * PW'(coef_c);
            r_sy      <= PW'(i_fy) * PW'(coef_s);
            r_rw      <= PW'(i_fw) * PW'(coef_r);
            r_b1_stop <= i_stop;
        end
    end

    // Stage 2: wheel sums and clamp.
    logic signed [SW-1:0] lim, sum_one, sum_two, sum_three;
    logic signed [SW-1:0] cl_one, cl_two, cl_three;

    function automatic logic signed [SW-1:0] clamp(input logic signed [SW-1:0] v,
                                                   input logic signed [SW-1:0] l);
        logic signed [SW-1:0] res;
        if (v >= l) begin
            res = l;
        end else if (v <= -l) begin
            res = -l;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign lim       = signed'(SW'({i_limit, {Q16_SH{1'b0}}}));
    assign sum_one   = SW'(r_ax) + SW'(r_cy) + SW'(r_rw);
    assign sum_two   = SW'(r_rw) - SW'(r_sy);
    assign sum_three = SW'(r_cy) + SW'(r_rw) - SW'(r_ax);
    assign cl_one    = clamp(sum_one, lim);
    assign cl_two    = clamp(sum_two, lim);
    assign cl_three  = clamp(sum_three, lim);

    logic signed [WHEEL_W-1:0] r_wheel_one, r_wheel_two, r_wheel_three;
    logic                      r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_b1_valid;
        end
        if (en_out && r_b1_valid) begin
            r_wheel_one   <= cl_one[WHEEL_W-1:0];
            r_wheel_two   <= cl_two[WHEEL_W-1:0];
            r_wheel_three <= cl_three[WHEEL_W-1:0];
            r_stop        <= r_b1_stop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wheel_one    = r_wheel_one;
    assign o_wheel_two    = r_wheel_two;
    assign o_wheel_three  = r_wheel_three;
    assign o_stop_request = r_stop;

    a_b1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !en_out) |=> r_b1_valid)
        else $error("product stage dropped a word under stall");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_stop) |->
            (r_wheel_one == '0) && (r_wheel_two == '0) && (r_wheel_three == '0))
        else $error("stop word with nonzero wheel");

endmodule

`default_nettype wire

// ===== hw/rtl/omni_wheel_velocity_mixer.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_velocity_mixer: inverse kinematics for a three-wheel omni base
// Path: an accepted word passes the front stages, the queue, the product register
// and the output register, and only the output stall can hold it back.
// Throughput: one word per clock, limited only by the output stall; the
// four-entry queue absorbs the words in flight in the front.
// Reset: synchronous, active low; it empties the pipelines and the queue and
// restores the velocity limit to 40. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

// The front classifies each command word. A polar heading in the range
// 0..359 degrees is folded into the first quadrant, looked up in a constant
// sine table and scaled by the magnitude, truncating toward zero. Other
// headings become a pure spin, and cartesian words pass through with the
// all-zero stop check. The back mixes the three body velocities into wheel
// speeds with the coefficient set of the command's mode, clamps them to the
// velocity limit in Q16 and holds them in an output register.
//
// The front never stalls internally. Instead the input is stalled whenever
// the words already in the queue plus those still in the front could fill
// it, so every word that enters the front has a queue entry waiting.
module omni_wheel_velocity_mixer #(
    parameter int TRIG_FRAC_BITS = owvm_pkg::TRIG_FRAC_BITS_DEF,
    parameter int CMD_WIDTH      = owvm_pkg::CMD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration: velocity limit.
    input  logic                                  i_cfg_we,
    input  logic [owvm_pkg::LIMIT_W-1:0]          i_cfg_wdata,
    // Command channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic signed [owvm_pkg::ANGLE_W-1:0]   i_angle_deg,
    input  logic signed [CMD_WIDTH-1:0]           i_magnitude,
    input  logic signed [CMD_WIDTH-1:0]           i_vel_x,
    input  logic signed [CMD_WIDTH-1:0]           i_vel_y,
    input  logic signed [CMD_WIDTH-1:0]           i_rotation,
    // Result channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [owvm_pkg::WHEEL_W-1:0]   o_wheel_one,
    output logic signed [owvm_pkg::WHEEL_W-1:0]   o_wheel_two,
    output logic signed [owvm_pkg::WHEEL_W-1:0]   o_wheel_three,
    output logic                                  o_stop_request
);
    import owvm_pkg::*;

    localparam int FW    = CMD_WIDTH + 1;
    localparam int QW    = 3 * FW + 2;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Velocity limit register; the user must write it only while the block is idle, as the block does not enforce this.
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    logic                 accept;
    logic                 push, f_cart, f_stop;
    logic signed [FW-1:0] f_fx, f_fy, f_fw;
    logic [1:0]           inflight;
    logic [CNT_W-1:0]     q_count;
    logic                 q_empty, pop;
    logic [QW-1:0]        q_wdata, q_rdata;
    logic [CNT_W:0]       occupancy;

    // Reserve a queue entry for every word still in the front.
    assign occupancy  = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(inflight);
    assign o_in_stall = (occupancy >= (CNT_W + 1)'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    owvm_front #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .CMD_WIDTH      (CMD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_angle_deg (i_angle_deg),
        .i_magnitude (i_magnitude),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_rotation  (i_rotation),
        .o_push      (push),
        .o_cart      (f_cart),
        .o_stop      (f_stop),
        .o_fx        (f_fx),
        .o_fy        (f_fy),
        .o_fw        (f_fw),
        .o_inflight  (inflight)
    );

    assign q_wdata = {f_cart, f_stop, f_fx, f_fy, f_fw};

    owvm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    owvm_back #(
        .CMD_WIDTH (CMD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_limit        (r_limit),
        .i_q_empty      (q_empty),
        .i_cart         (q_rdata[QW-1]),
        .i_stop         (q_rdata[QW-2]),
        .i_fx           (q_rdata[3*FW-1:2*FW]),
        .i_fy           (q_rdata[2*FW-1:FW]),
        .i_fw           (q_rdata[FW-1:0]),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_wheel_one    (o_wheel_one),
        .o_wheel_two    (o_wheel_two),
        .o_wheel_three  (o_wheel_three),
        .o_stop_request (o_stop_request)
    );

endmodule

`default_nettype wire
